@@ rtl/mcc_pkg.sv @@
package mcc_pkg;

	localparam int DEF_MAX_AMOUNT = 63;
	localparam int DEF_NUM_COINS  = 4;

	localparam int COIN_W      = 6;
	localparam int COUNT_W     = 7;
	localparam int NUM_COIN_REGS = 4;
	localparam int CFG_ADDR_W  = 5;
	localparam int CFG_DATA_W  = 32;

	// count code for an amount that cannot be made
	localparam logic [COUNT_W-1:0] NO_WAY = 7'd127;

	localparam logic [2:0]        RST_COINS_IN_USE = 3'd4;
	localparam logic [COIN_W-1:0] RST_COIN_A       = 6'd1;
	localparam logic [COIN_W-1:0] RST_COIN_B       = 6'd5;
	localparam logic [COIN_W-1:0] RST_COIN_C       = 6'd6;
	localparam logic [COIN_W-1:0] RST_COIN_D       = 6'd9;

	typedef enum logic [2:0] {
		REG_COINS_IN_USE,
		REG_COIN_A,
		REG_COIN_B,
		REG_COIN_C,
		REG_COIN_D
	} mcc_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_FILL,
		ST_DRAIN,
		ST_TRACE
	} mcc_state_t;

	typedef struct packed {
		logic [2:0]                           coins_in_use;
		logic [NUM_COIN_REGS-1:0][COIN_W-1:0] coin;
	} mcc_cfg_t;

	// one table entry: best count and the coin that reached it
	typedef struct packed {
		logic [COUNT_W-1:0] best;
		logic [COIN_W-1:0]  chosen;
	} mcc_entry_t;

	typedef struct packed {
		logic              valid;
		logic              reachable;
		logic [COIN_W-1:0] total;
		logic [COIN_W-1:0] value;
		logic              last;
	} mcc_result_t;

endpackage

@@ rtl/min_coin_change_solver.sv @@
// minimum coin change solver
//
// configuration: apb-style port, registers at byte addresses 0 (coins_in_use),
// 4, 8, 12, 16 (coin_a .. coin_d). pready is always high; write only while idle.
// input: a target word is taken at a clock edge with start high and busy low.
// the block rebuilds a table of the least coin count for every amount up to
// the target in one single-port-read memory, one coin per amount per cycle,
// then traces back from the target one coin per cycle.
// output: each result word shows on the result ports for one cycle with
// result_valid high; the receiver cannot stall, so words are never held.
// a trace emits one word per cycle back to back, the last one marked.
// the fill is bound by the one table read per coin and amount.
// throughput: busy drops as the last word shows, so the next target can be
// taken at the edge that takes the last word.
// a zero target is answered without a fill, an out-of-range target from idle.
// reset: asynchronous, restores the default coin set; the table needs no
// clearing since every entry read is first rewritten for that target.
module min_coin_change_solver import mcc_pkg::*; #(
	parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
	parameter int NUM_COINS  = DEF_NUM_COINS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  logic [COIN_W-1:0]     target_amount,
	output logic                  result_valid,
	output logic                  reachable,
	output logic [COIN_W-1:0]     coin_total,
	output logic [COIN_W-1:0]     coin_value,
	output logic                  last_of_run
);

	mcc_cfg_t cfg;

	mcc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	mcc_engine #(
		.MAX_AMOUNT(MAX_AMOUNT),
		.NUM_COINS (NUM_COINS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.start        (start),
		.target_amount(target_amount),
		.busy         (busy),
		.result_valid (result_valid),
		.reachable    (reachable),
		.coin_total   (coin_total),
		.coin_value   (coin_value),
		.last_of_run  (last_of_run)
	);

endmodule

@@ rtl/mcc_ram.sv @@
module mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/mcc_cfg.sv @@
module mcc_cfg import mcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output mcc_cfg_t              cfg
);

	mcc_cfg_t cfg_q;
	mcc_reg_t reg_idx;
	logic     wr_hit;

	assign pready  = 1'b1;
	assign reg_idx = mcc_reg_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_hit  = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coins_in_use <= RST_COINS_IN_USE;
			cfg_q.coin[0]      <= RST_COIN_A;
			cfg_q.coin[1]      <= RST_COIN_B;
			cfg_q.coin[2]      <= RST_COIN_C;
			cfg_q.coin[3]      <= RST_COIN_D;
		end else if (wr_hit) begin
			unique case (reg_idx)
				REG_COINS_IN_USE: cfg_q.coins_in_use <= pwdata[2:0];
				REG_COIN_A:       cfg_q.coin[0] <= pwdata[COIN_W-1:0];
				REG_COIN_B:       cfg_q.coin[1] <= pwdata[COIN_W-1:0];
				REG_COIN_C:       cfg_q.coin[2] <= pwdata[COIN_W-1:0];
				REG_COIN_D:       cfg_q.coin[3] <= pwdata[COIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_COINS_IN_USE: prdata = CFG_DATA_W'(cfg_q.coins_in_use);
			REG_COIN_A:       prdata = CFG_DATA_W'(cfg_q.coin[0]);
			REG_COIN_B:       prdata = CFG_DATA_W'(cfg_q.coin[1]);
			REG_COIN_C:       prdata = CFG_DATA_W'(cfg_q.coin[2]);
			REG_COIN_D:       prdata = CFG_DATA_W'(cfg_q.coin[3]);
			default:          prdata = '0;
		endcase
	end

endmodule

@@ rtl/mcc_engine.sv @@
module mcc_engine import mcc_pkg::*; #(
	parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
	parameter int NUM_COINS  = DEF_NUM_COINS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mcc_cfg_t          cfg,
	input  logic              start,
	input  logic [COIN_W-1:0] target_amount,
	output logic              busy,
	output logic              result_valid,
	output logic              reachable,
	output logic [COIN_W-1:0] coin_total,
	output logic [COIN_W-1:0] coin_value,
	output logic              last_of_run
);

	localparam int DEPTH = MAX_AMOUNT + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = $bits(mcc_entry_t);

	mcc_state_t state_q, state_d;

	logic [COIN_W-1:0] target_q;
	logic [AW-1:0]     amt_q;
	logic [1:0]        j_q;

	// compare stage
	logic              valid_s1, last_s1, first_s1, skip_s1;
	logic [AW-1:0]     amt_s1;
	logic [COIN_W-1:0] coin_s1;
	logic [COUNT_W-1:0] best_q;
	logic [COIN_W-1:0]  chosen_q;

	// read forwarding
	logic       fwd_q;
	mcc_entry_t fwd_data_q;

	// traceback
	logic [AW-1:0]      rem_q;
	logic [COIN_W-1:0]  pend_q;
	logic [COUNT_W-1:0] total_q;
	logic               tr_first_q;

	// result register
	logic              strobe_q, reach_q, last_q;
	logic [COIN_W-1:0] total_out_q, value_q;

	logic       wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	mcc_entry_t wr_data, ram_rdata, rd_eff, new_entry;
	mcc_result_t emit;

	logic [2:0]        used, slots_m1;
	logic [COIN_W-1:0] slot_coin, amt_ext;
	logic              last_slot, slot_skip, fill_done;

	logic [COUNT_W-1:0] base_best, cand;
	logic [COIN_W-1:0]  base_ch;
	logic               improve;

	logic [COIN_W-1:0] tr_c;
	logic              tr_ok, tr_stop;
	logic [AW-1:0]     tr_next;

	logic accept, in_range;

	mcc_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rdata)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = (target_amount <= COIN_W'(MAX_AMOUNT));

	// slot decode: one slot per coin tried, at least one per amount
	always_comb begin
		used      = (cfg.coins_in_use > 3'(NUM_COINS)) ? 3'(NUM_COINS) : cfg.coins_in_use;
		slots_m1  = (used == 3'd0) ? 3'd0 : used - 3'd1;
		slot_coin = cfg.coin[j_q];
		amt_ext   = COIN_W'(amt_q);
		last_slot = ({1'b0, j_q} == slots_m1);
		slot_skip = ({1'b0, j_q} >= used) || (slot_coin == '0) || (slot_coin > amt_ext);
		fill_done = last_slot && (amt_q == target_q[AW-1:0]);
	end

	// compare stage, running best kept in registers
	always_comb begin
		rd_eff    = fwd_q ? fwd_data_q : ram_rdata;
		base_best = first_s1 ? NO_WAY : best_q;
		base_ch   = first_s1 ? '0 : chosen_q;
		cand      = rd_eff.best + COUNT_W'(1);
		improve   = !skip_s1 && (rd_eff.best != NO_WAY) && (cand < base_best);
		new_entry.best   = improve ? cand : base_best;
		new_entry.chosen = improve ? coin_s1 : base_ch;
	end

	always_comb begin
		tr_c    = rd_eff.chosen;
		tr_ok   = (rem_q != '0) && (tr_c != '0) && (tr_c <= COIN_W'(rem_q));
		tr_next = rem_q - tr_c[AW-1:0];
		tr_stop = tr_first_q ? ((rd_eff.best == NO_WAY) || !tr_ok) : !tr_ok;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_range) begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO:  state_d = (target_q == '0) ? ST_IDLE : ST_FILL;
			ST_FILL: begin
				if (fill_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_TRACE;
			ST_TRACE: begin
				if (tr_stop) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en   = valid_s1 && last_s1;
		wr_addr = amt_s1;
		wr_data = new_entry;
		rd_en   = 1'b0;
		rd_addr = '0;
		emit    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !in_range) begin
					emit.valid = 1'b1;
					emit.last  = 1'b1;
				end
			end
			ST_ZERO: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '0;
				if (target_q == '0) begin
					emit.valid     = 1'b1;
					emit.reachable = 1'b1;
					emit.last      = 1'b1;
				end
			end
			ST_FILL: begin
				rd_en   = !slot_skip;
				rd_addr = amt_q - slot_coin[AW-1:0];
			end
			ST_DRAIN: begin
				// target entry is written now, forwarding picks it up
				rd_en   = 1'b1;
				rd_addr = target_q[AW-1:0];
			end
			ST_TRACE: begin
				if (tr_first_q) begin
					if (rd_eff.best == NO_WAY) begin
						emit.valid = 1'b1;
						emit.last  = 1'b1;
					end else if (!tr_ok) begin
						emit.valid     = 1'b1;
						emit.reachable = 1'b1;
						emit.total     = rd_eff.best[COIN_W-1:0];
						emit.last      = 1'b1;
					end
				end else begin
					// the held coin goes out once the next step is known
					emit.valid     = 1'b1;
					emit.reachable = 1'b1;
					emit.total     = total_q[COIN_W-1:0];
					emit.value     = pend_q;
					emit.last      = !tr_ok;
				end
				if (tr_ok && !(tr_first_q && rd_eff.best == NO_WAY)) begin
					rd_en   = 1'b1;
					rd_addr = tr_next;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			amt_q      <= '0;
			j_q        <= '0;
			valid_s1   <= 1'b0;
			fwd_q      <= 1'b0;
			tr_first_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			valid_s1   <= (state_q == ST_FILL);
			fwd_q      <= wr_en && rd_en && (wr_addr == rd_addr);
			tr_first_q <= (state_q == ST_DRAIN);
			strobe_q   <= emit.valid;
			if (state_q == ST_ZERO) begin
				amt_q <= AW'(1);
				j_q   <= '0;
			end else if (state_q == ST_FILL) begin
				if (last_slot) begin
					amt_q <= amt_q + AW'(1);
					j_q   <= '0;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= target_amount;
		end
		last_s1    <= last_slot;
		first_s1   <= (j_q == 2'd0);
		skip_s1    <= slot_skip;
		amt_s1     <= amt_q;
		coin_s1    <= slot_coin;
		fwd_data_q <= wr_data;
		if (valid_s1) begin
			best_q   <= new_entry.best;
			chosen_q <= new_entry.chosen;
		end
		if (state_q == ST_DRAIN) begin
			rem_q <= target_q[AW-1:0];
		end else if (state_q == ST_TRACE && tr_ok) begin
			rem_q  <= tr_next;
			pend_q <= tr_c;
		end
		if (state_q == ST_TRACE && tr_first_q) begin
			total_q <= rd_eff.best;
		end
		if (emit.valid) begin
			reach_q     <= emit.reachable;
			total_out_q <= emit.total;
			value_q     <= emit.value;
			last_q      <= emit.last;
		end
	end

	assign result_valid = strobe_q;
	assign reachable    = reach_q;
	assign coin_total   = total_out_q;
	assign coin_value   = value_q;
	assign last_of_run  = last_q;

endmodule

@@ rtl/mcc_checker.sv @@
module mcc_checker import mcc_pkg::*; #(
	parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [COIN_W-1:0] target_amount,
	input logic              result_valid,
	input logic              reachable,
	input logic [COIN_W-1:0] coin_total,
	input logic [COIN_W-1:0] coin_value,
	input logic              last_of_run
);

	// an in-range target always starts a run
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (target_amount <= COIN_W'(MAX_AMOUNT)) |=> busy)
		else $error("in-range target did not start a run");

	a_impossible_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !reachable |-> last_of_run && coin_total == '0 && coin_value == '0)
		else $error("impossible answer not a single empty word");

	// traced words come back to back with the same total
	a_trace_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |=> result_valid && $stable(coin_total))
		else $error("trace run broken or total changed");

	a_trace_coin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |-> reachable && coin_value != '0 && busy)
		else $error("non-final word without a coin");

endmodule

bind min_coin_change_solver mcc_checker #(
	.MAX_AMOUNT(MAX_AMOUNT)
) u_mcc_checker (.*);

@@ verif/min_coin_change_solver_tb.sv @@
`timescale 1ns / 100ps

module min_coin_change_solver_tb;
	import mcc_pkg::*;

	typedef struct packed {
		logic              reachable;
		logic [COIN_W-1:0] total;
		logic [COIN_W-1:0] value;
		logic              last;
	} coin_word_t;

	typedef struct {
		logic [COIN_W-1:0] target;
		int                gap;
	} target_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  start = 1'b0;
	logic                  busy;
	logic [COIN_W-1:0]     target_amount = '0;
	logic                  result_valid;
	logic                  reachable;
	logic [COIN_W-1:0]     coin_total;
	logic [COIN_W-1:0]     coin_value;
	logic                  last_of_run;

	// our copy of the coin set
	logic [2:0]        mdl_used;
	logic [COIN_W-1:0] mdl_coin [NUM_COIN_REGS];

	target_req_t target_backlog[$];
	coin_word_t  coin_words_due[$];
	target_req_t cur_req;
	logic        loaded = 1'b0;
	logic        offering = 1'b0;
	logic        word_taken = 1'b0;
	int          gap_left = 0;

	int errors = 0;
	int targets_done = 0;
	int words_seen = 0;
	int unreach_seen = 0;
	int settings_run = 0;

	min_coin_change_solver u_dut (.*);

	always #5 clk = ~clk;

	function automatic coin_word_t make_word(logic ok, logic [COIN_W-1:0] total,
			logic [COIN_W-1:0] value, logic last);
		coin_word_t w;
		w.reachable = ok;
		w.total     = total;
		w.value     = value;
		w.last      = last;
		return w;
	endfunction

	// least-coin table up to the target, then trace back one word per coin
	function automatic void solve_change(logic [COIN_W-1:0] target);
		logic [COUNT_W-1:0] best [64];
		logic [COIN_W-1:0]  pick [64];
		coin_word_t         w;
		int                 used;
		int                 c;
		int                 prev;
		int                 rem;
		int                 k;
		used = (mdl_used > DEF_NUM_COINS) ? DEF_NUM_COINS : int'(mdl_used);
		best[0] = '0;
		pick[0] = '0;
		for (int amt = 1; amt <= int'(target); amt++) begin
			best[amt] = NO_WAY;
			pick[amt] = '0;
			for (int j = 0; j < used; j++) begin
				c = mdl_coin[j];
				if (c == 0 || c > amt)
					continue;
				prev = best[amt - c];
				if (prev == NO_WAY)
					continue;
				// strictly smaller only, so the earlier coin keeps a tie
				if (prev + 1 < best[amt]) begin
					best[amt] = COUNT_W'(prev + 1);
					pick[amt] = COIN_W'(c);
				end
			end
		end
		if (best[target] == NO_WAY) begin
			coin_words_due.push_back(make_word(1'b0, '0, '0, 1'b1));
			return;
		end
		if (target == 0) begin
			coin_words_due.push_back(make_word(1'b1, '0, '0, 1'b1));
			return;
		end
		k = 0;
		rem = target;
		while (rem > 0 && k < 63) begin
			c = pick[rem];
			if (c == 0 || c > rem)
				break;
			rem -= c;
			coin_words_due.push_back(make_word(1'b1, best[target][COIN_W-1:0],
				COIN_W'(c), 1'b0));
			k++;
		end
		if (k == 0) begin
			coin_words_due.push_back(make_word(1'b1, best[target][COIN_W-1:0], '0, 1'b1));
		end else begin
			w = coin_words_due.pop_back();
			w.last = 1'b1;
			coin_words_due.push_back(w);
		end
	endfunction

	// check result words, then take note of an accepted target
	always @(posedge clk) begin : mon
		coin_word_t want;
		if (arst_n) begin
			if (result_valid) begin
				words_seen++;
				if (!reachable)
					unreach_seen++;
				if (coin_words_due.size() == 0) begin
					errors++;
					$error("unexpected word: reachable %0d total %0d value %0d last %0d",
						reachable, coin_total, coin_value, last_of_run);
				end else begin
					want = coin_words_due.pop_front();
					if (reachable !== want.reachable) begin
						errors++;
						$error("reachable: expected %0d, got %0d", want.reachable, reachable);
					end
					if (coin_total !== want.total) begin
						errors++;
						$error("coin_total: expected %0d, got %0d", want.total, coin_total);
					end
					if (coin_value !== want.value) begin
						errors++;
						$error("coin_value: expected %0d, got %0d", want.value, coin_value);
					end
					if (last_of_run !== want.last) begin
						errors++;
						$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
					end
				end
			end
			if (start && !busy) begin
				solve_change(target_amount);
				targets_done++;
				word_taken = 1'b1;
			end
		end
	end

	always @(negedge clk) begin : drv
		if (arst_n) begin
			if (word_taken) begin
				word_taken = 1'b0;
				offering = 1'b0;
			end
			if (!offering && !loaded && target_backlog.size() != 0) begin
				cur_req = target_backlog.pop_front();
				gap_left = cur_req.gap;
				loaded = 1'b1;
			end
			if (loaded) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					loaded = 1'b0;
					offering = 1'b1;
				end
			end
			start <= offering;
			target_amount <= offering ? cur_req.target : COIN_W'($urandom);
		end
	end

	task automatic queue_target(int target, int gap);
		target_req_t r;
		r.target = COIN_W'(target);
		r.gap = gap;
		target_backlog.push_back(r);
	endtask

	// sender holds off until every word due has come back and the block is idle
	task automatic wait_drained();
		do @(negedge clk);
		while (target_backlog.size() != 0 || loaded || offering || coin_words_due.size() != 0);
		while (busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(mcc_reg_t idx, logic [COIN_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= CFG_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COINS_IN_USE: mdl_used = val[2:0];
			REG_COIN_A:       mdl_coin[0] = val;
			REG_COIN_B:       mdl_coin[1] = val;
			REG_COIN_C:       mdl_coin[2] = val;
			REG_COIN_D:       mdl_coin[3] = val;
			default: ;
		endcase
	endtask

	task automatic set_coins(logic [2:0] used, logic [COIN_W-1:0] a, logic [COIN_W-1:0] b,
			logic [COIN_W-1:0] c, logic [COIN_W-1:0] d);
		write_reg(REG_COINS_IN_USE, COIN_W'(used));
		write_reg(REG_COIN_A, a);
		write_reg(REG_COIN_B, b);
		write_reg(REG_COIN_C, c);
		write_reg(REG_COIN_D, d);
		settings_run++;
	endtask

	function automatic logic [COIN_W-1:0] rand_coin();
		if ($urandom_range(0, 9) == 0)
			return COIN_W'($urandom_range(0, 63));
		return COIN_W'($urandom_range(1, 12));
	endfunction

	initial begin : stim
		logic       burst;
		logic [2:0] used;
		mdl_used    = RST_COINS_IN_USE;
		mdl_coin[0] = RST_COIN_A;
		mdl_coin[1] = RST_COIN_B;
		mdl_coin[2] = RST_COIN_C;
		mdl_coin[3] = RST_COIN_D;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset coin set 1, 5, 6, 9; 10 ties between 1+9 and 5+5
		settings_run++;
		queue_target(0, $urandom_range(0, 17));
		queue_target(63, 0);
		queue_target(1, 0);
		queue_target(10, $urandom_range(0, 17));
		queue_target(11, $urandom_range(0, 17));
		queue_target(13, 0);
		queue_target(62, $urandom_range(0, 17));
		wait_drained();

		// no coins at all
		set_coins(3'd0, 6'd1, 6'd2, 6'd3, 6'd4);
		queue_target(0, 0);
		queue_target(5, $urandom_range(0, 17));
		queue_target(63, 0);
		wait_drained();

		// count above four saturates; a zero coin never wins
		set_coins(3'd7, 6'd63, 6'd2, 6'd0, 6'd4);
		queue_target(63, 0);
		queue_target(1, $urandom_range(0, 17));
		queue_target(62, 0);
		queue_target(3, $urandom_range(0, 17));
		queue_target(0, 0);
		wait_drained();

		// only ones: longest trace
		set_coins(3'd1, 6'd1, 6'd63, 6'd63, 6'd63);
		queue_target(63, $urandom_range(0, 17));
		queue_target(0, 0);
		queue_target(32, 0);
		wait_drained();

		set_coins(3'd2, 6'd7, 6'd3, 6'd1, 6'd1);
		queue_target(2, 0);
		queue_target(11, $urandom_range(0, 17));
		queue_target(5, 0);

		for (int p = 0; p < 8; p++) begin
			burst = (p % 3 == 1);
			wait_drained();
			used = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 4));
			set_coins(used, rand_coin(), rand_coin(), rand_coin(), rand_coin());
			for (int i = 0; i < 24; i++) begin
				if (i == 12 && p % 2 == 1)
					wait_drained();
				queue_target($urandom_range(0, 63), burst ? 0 : $urandom_range(0, 17));
			end
		end
		wait_drained();
		repeat (20) @(negedge clk);

		$display("%0d targets solved under %0d coin sets, %0d result words checked",
			targets_done, settings_run, words_seen);
		$display("%0d unreachable answers seen", unreach_seen);
		if (errors == 0 && coin_words_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
